// ===== rtl/keyboard_matrix_to_hid_report_defines.svh =====
// Assertion macros shared by the keyboard matrix to HID report block.
// Included by the top level; depends on signals named clk and rst_n in scope.
`ifndef KEYBOARD_MATRIX_TO_HID_REPORT_DEFINES_SVH
`define KEYBOARD_MATRIX_TO_HID_REPORT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMH_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard report check failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define KMH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard report check failed (next cycle)");

`endif

// ===== rtl/kmhid_pkg.sv =====
// Package for the keyboard matrix to HID report block: code type, keycode ROMs,
// modifier bit positions and the per-position visit struct. No dependencies.
package kmhid_pkg;

    typedef logic [7:0] code_t;

    // One matrix position as presented to the slot unit.
    typedef struct packed {
        code_t code;
        logic  pressed;
    } visit_t;

    localparam int    MATRIX_POSITIONS = 64;
    localparam int    POS_W            = 6;
    localparam int    OUT_SLOTS        = 6;
    localparam int    SLOT_STORE       = 16;
    localparam code_t NO_CODE          = 8'h00;

    // HID modifier bits.
    localparam int MOD_CTRL_BIT  = 0;
    localparam int MOD_SHIFT_BIT = 1;
    localparam int MOD_GUI_BIT   = 3;

    localparam code_t PLAIN_ROM [MATRIX_POSITIONS] = '{
        8'h0D, 8'h0F, 8'h11, 8'h13, 8'h0C, 8'h0E, 8'h10, 8'h12,
        8'h1D, 8'h1E, 8'h20, 8'h22, 8'h1C, 8'h27, 8'h1F, 8'h21,
        8'h37, 8'h29, 8'h28, 8'h2A, 8'h36, 8'h38, 8'h2C, 8'h00,
        8'h05, 8'h07, 8'h09, 8'h0B, 8'h04, 8'h06, 8'h08, 8'h0A,
        8'h15, 8'h17, 8'h19, 8'h1B, 8'h14, 8'h16, 8'h18, 8'h1A,
        8'h24, 8'h26, 8'h2F, 8'h34, 8'h23, 8'h25, 8'h2D, 8'h33,
        8'h2E, 8'h76, 8'h40, 8'h3C, 8'h2B, 8'h30, 8'h3F, 8'h3A,
        8'h3E, 8'h00, 8'h00, 8'h00, 8'h3D, 8'h3B, 8'h00, 8'h00
    };

    localparam code_t SPECIAL_ROM [MATRIX_POSITIONS] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h4F, 8'h4E, 8'h00, 8'h50, 8'h00, 8'h4D, 8'h00,
        8'h4B, 8'h00, 8'h00, 8'h2A, 8'h4A, 8'h51, 8'h00, 8'h52,
        8'h00, 8'h00, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h64, 8'h00, 8'h00, 8'h43, 8'h00, 8'h32, 8'h68, 8'h41,
        8'h45, 8'h00, 8'h00, 8'h00, 8'h44, 8'h42, 8'h00, 8'h00
    };

    // Keycode at a matrix position, from the table the special line selects.
    function automatic code_t rom_code(input logic special, input logic [POS_W-1:0] pos);
        code_t code;
        if (special)
        begin
            code = SPECIAL_ROM[pos];
        end
        else
        begin
            code = PLAIN_ROM[pos];
        end
        return code;
    endfunction

endpackage

// ===== rtl/keyboard_matrix_to_hid_report.sv =====
// Keyboard matrix to HID report, top level (uses kmhid_pkg, kmhid_slot_unit and the
// assertion macros in keyboard_matrix_to_hid_report_defines.svh). One input transfer
// carries a full scan: four modifier lines and eight row sense bytes. The scan is
// latched, then a sequencer walks the 64 matrix positions row by row, column by
// column, one position per cycle through a single shared slot unit that compares
// the position's keycode against all key slots at once. A scan runs from one transfer
// to the earliest next one through the accept step in idle, one step per matrix
// position, and a finishing step that clears the set when no key was sensed
// and decides whether a report is due. A changed report is loaded into an output
// register; if an earlier report still waits there, the finishing step holds until
// it is taken. Unchanged scans give no output transfer. KEY_SLOTS sets the slot
// count (1 to 16, larger values act as 16); slot outputs at or above it read zero.
module keyboard_matrix_to_hid_report #(
    parameter int KEY_SLOTS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       shift_line,
    input  logic       control_line,
    input  logic       special_line,
    input  logic       alt_line,
    input  logic [7:0] row0_sense,
    input  logic [7:0] row1_sense,
    input  logic [7:0] row2_sense,
    input  logic [7:0] row3_sense,
    input  logic [7:0] row4_sense,
    input  logic [7:0] row5_sense,
    input  logic [7:0] row6_sense,
    input  logic [7:0] row7_sense,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] modifier_byte,
    output logic [7:0] slot0_code,
    output logic [7:0] slot1_code,
    output logic [7:0] slot2_code,
    output logic [7:0] slot3_code,
    output logic [7:0] slot4_code,
    output logic [7:0] slot5_code
);

    `include "keyboard_matrix_to_hid_report_defines.svh"

    localparam int SLOT_N = (KEY_SLOTS > kmhid_pkg::SLOT_STORE) ? kmhid_pkg::SLOT_STORE
                                                                 : KEY_SLOTS;
    localparam int POS_W  = kmhid_pkg::POS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(kmhid_pkg::MATRIX_POSITIONS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [POS_W-1:0]            pos_reg;
    logic [kmhid_pkg::MATRIX_POSITIONS-1:0] sense_reg;
    logic                        special_reg;
    logic                        any_reg;
    logic [3:0]                  mods_reg;
    logic [3:0]                  sent_reg;
    kmhid_pkg::code_t            slots_reg  [SLOT_N];
    kmhid_pkg::code_t            before_reg [SLOT_N];
    kmhid_pkg::code_t            slots_step [SLOT_N];
    kmhid_pkg::code_t            final_slots [SLOT_N];
    kmhid_pkg::code_t            report_slots [kmhid_pkg::OUT_SLOTS];
    kmhid_pkg::code_t            slot_out_reg [kmhid_pkg::OUT_SLOTS];
    logic [3:0]                  mod_out_reg;
    logic                        out_valid_reg;
    kmhid_pkg::visit_t           visit;
    logic                        in_xfer;
    logic                        out_free;
    logic                        changed;
    logic                        done_leave;
    logic [3:0]                  mods_in;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Modifier mapping of the raw lines.
    always_comb
    begin
        mods_in = 4'd0;
        mods_in[kmhid_pkg::MOD_CTRL_BIT]  = control_line;
        mods_in[kmhid_pkg::MOD_SHIFT_BIT] = shift_line;
        mods_in[kmhid_pkg::MOD_GUI_BIT]   = alt_line;
    end

    // Position under visit, looked up in the selected ROM.
    assign visit.code    = kmhid_pkg::rom_code(special_reg, pos_reg);
    assign visit.pressed = sense_reg[pos_reg];

    kmhid_slot_unit #(
        .N (SLOT_N)
    ) u_slot_unit (
        .visit     (visit),
        .slots_in  (slots_reg),
        .slots_out (slots_step)
    );

    // End of scan: clear the set when nothing was sensed, then look for changes.
    always_comb
    begin
        changed = (mods_reg != sent_reg);
        for (int i = 0; i < SLOT_N; i++)
        begin
            final_slots[i] = any_reg ? slots_reg[i] : kmhid_pkg::NO_CODE;
            changed        = changed | (final_slots[i] != before_reg[i]);
        end
    end

    // Report fields; slots beyond the configured count read zero.
    for (genvar j = 0; j < kmhid_pkg::OUT_SLOTS; j++)
    begin : g_report
        if (j < SLOT_N)
        begin : g_used
            assign report_slots[j] = final_slots[j];
        end
        else
        begin : g_unused
            assign report_slots[j] = kmhid_pkg::NO_CODE;
        end
    end

    assign done_leave = (state_reg == ST_DONE) && (!changed || out_free);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pos_reg == LAST_POS)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_leave)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, slot set and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sent_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_N; i++)
            begin
                slots_reg[i] <= kmhid_pkg::NO_CODE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                pos_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pos_reg <= pos_reg + 1'b1;
            end

            if (state_reg == ST_SCAN)
            begin
                slots_reg <= slots_step;
            end
            else if (done_leave)
            begin
                slots_reg <= final_slots;
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (done_leave && changed)
            begin
                out_valid_reg <= 1'b1;
                sent_reg      <= mods_reg;
            end
        end
    end

    // Latched scan and report payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sense_reg   <= {row7_sense, row6_sense, row5_sense, row4_sense,
                            row3_sense, row2_sense, row1_sense, row0_sense};
            special_reg <= special_line;
            any_reg     <= |{row7_sense, row6_sense, row5_sense, row4_sense,
                             row3_sense, row2_sense, row1_sense, row0_sense};
            mods_reg    <= mods_in;
            before_reg  <= slots_reg;
        end
        if (done_leave && changed)
        begin
            mod_out_reg  <= mods_reg;
            slot_out_reg <= report_slots;
        end
    end

    assign out_valid     = out_valid_reg;
    assign modifier_byte = mod_out_reg;
    assign slot0_code    = slot_out_reg[0];
    assign slot1_code    = slot_out_reg[1];
    assign slot2_code    = slot_out_reg[2];
    assign slot3_code    = slot_out_reg[3];
    assign slot4_code    = slot_out_reg[4];
    assign slot5_code    = slot_out_reg[5];

    // A transfer always starts a scan at the first position.
    `KMH_ASSERT_NEXT(a_xfer_starts_scan, in_xfer, (state_reg == ST_SCAN) && (pos_reg == '0))
    // The last position always hands over to the finishing step.
    `KMH_ASSERT_NEXT(a_last_pos_done, (state_reg == ST_SCAN) && (pos_reg == LAST_POS), state_reg == ST_DONE)
    // A new report only appears out of the finishing step.
    `KMH_ASSERT_NOW(a_report_from_done, $rose(out_valid), $past(state_reg) == ST_DONE)
    // Modifier bit two is never reported.
    `KMH_ASSERT_NOW(a_mod_bit2_zero, out_valid, !modifier_byte[2])

endmodule

// ===== rtl/kmhid_slot_unit.sv =====
// Shared slot update unit: applies one matrix position to the key slot set.
// Depends on kmhid_pkg.
module kmhid_slot_unit #(
    parameter int N = 6
) (
    input  kmhid_pkg::visit_t visit,
    input  kmhid_pkg::code_t  slots_in  [N],
    output kmhid_pkg::code_t  slots_out [N]
);

    logic [N-1:0] match;
    logic         hit;
    logic         placed;
    logic         cleared;

    // Parallel compare of the code against every slot.
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = (slots_in[i] == visit.code);
            hit      = hit | match[i];
        end
    end

    // A press fills the first empty slot when the code is absent; a release
    // empties the first slot that holds the code. A zero code does nothing.
    always_comb
    begin
        placed  = 1'b0;
        cleared = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            slots_out[i] = slots_in[i];
        end
        if (visit.code != kmhid_pkg::NO_CODE)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (visit.pressed)
                begin
                    if (!hit && !placed && (slots_in[i] == kmhid_pkg::NO_CODE))
                    begin
                        slots_out[i] = visit.code;
                        placed       = 1'b1;
                    end
                end
                else if (!cleared && match[i])
                begin
                    slots_out[i] = kmhid_pkg::NO_CODE;
                    cleared      = 1'b1;
                end
            end
        end
    end

endmodule
